/* sv/fvrc_pkg.sv */
// Shared types and constants of the value range count unit.
// No dependencies; every other file imports this package.
package fvrc_pkg;

  localparam int FIELD_W = 10;
  localparam int CNT_W   = 11;

  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_COUNT  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_OLD,
    S_NEW,
    S_HI,
    S_LO,
    S_RESULT
  } seq_state_e;

  typedef enum logic [1:0] {
    W_IDLE,
    W_READ,
    W_APPLY
  } walk_state_e;

  typedef struct packed {
    logic start;
    logic sum_mode;
    logic sub;
    logic clear_acc;
  } walk_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_sts_t;

endpackage

/* sv/fvrc_if.sv */
// Valid/ready channels of the value range count unit.
// Depends on fvrc_pkg for the field widths.
interface fvrc_in_if import fvrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [FIELD_W-1:0] employee;
  logic [FIELD_W-1:0] salary;
  logic [FIELD_W-1:0] low_value;
  logic [FIELD_W-1:0] high_value;

  modport source (output valid, action, employee, salary, low_value, high_value,
                  input ready);
  modport sink   (input valid, action, employee, salary, low_value, high_value,
                  output ready);
endinterface

interface fvrc_out_if import fvrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink   (input valid, count, output ready);
endinterface

/* sv/fvrc_walk.sv */
// Fenwick walk unit: tree count memory, index arithmetic and one shared count adder.
// Runs one update walk or one prefix walk per command. Depends on fvrc_pkg.
module fvrc_walk import fvrc_pkg::*; #(
  parameter int VALUE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  walk_cmd_t             cmd_i,
  input  logic [VALUE_BITS:0]   pos_i,
  input  logic                  clr_en_i,
  input  logic [VALUE_BITS-1:0] clr_addr_i,
  output walk_sts_t             sts_o,
  output logic [CNT_W-1:0]      acc_o
);

  localparam int VB    = VALUE_BITS;
  localparam int VSIZE = 1 << VB;
  localparam int IW    = VB + 2;

  logic [CNT_W-1:0] tree_mem [VSIZE];

  walk_state_e      state_q, state_d;
  logic             done_q, done_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             sum_q, sum_d;
  logic             sub_q, sub_d;
  logic [CNT_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] rd_q;

  logic [IW-1:0]    lowbit;
  logic [IW-1:0]    idx_m1;
  logic             in_range;
  logic [CNT_W-1:0] alu_a, alu_b, alu_res;
  logic             rd_en;
  logic             we;
  logic [VB-1:0]    waddr;
  logic [CNT_W-1:0] wdata;

  assign lowbit   = idx_q & (~idx_q + IW'(1));
  assign idx_m1   = idx_q - IW'(1);
  assign in_range = (idx_q != '0) && (sum_q || (idx_q <= IW'(VSIZE)));
  assign alu_a    = sum_q ? acc_q : rd_q;
  assign alu_b    = sum_q ? rd_q : CNT_W'(1);
  assign alu_res  = sub_q ? (alu_a - alu_b) : (alu_a + alu_b);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    idx_d   = idx_q;
    sum_d   = sum_q;
    sub_d   = sub_q;
    acc_d   = acc_q;
    rd_en   = 1'b0;
    case (state_q)
      W_IDLE: begin
        if (cmd_i.start) begin
          idx_d   = IW'(pos_i);
          sum_d   = cmd_i.sum_mode;
          sub_d   = cmd_i.sub;
          if (cmd_i.clear_acc) begin
            acc_d = '0;
          end
          state_d = W_READ;
        end
      end
      W_READ: begin
        if (in_range) begin
          rd_en   = 1'b1;
          state_d = W_APPLY;
        end else begin
          done_d  = 1'b1;
          state_d = W_IDLE;
        end
      end
      W_APPLY: begin
        if (sum_q) begin
          acc_d = alu_res;
          idx_d = idx_q - lowbit;
        end else begin
          idx_d = idx_q + lowbit;
        end
        state_d = W_READ;
      end
      default: state_d = W_IDLE;
    endcase
  end

  assign we    = clr_en_i || ((state_q == W_APPLY) && !sum_q);
  assign waddr = clr_en_i ? clr_addr_i : idx_m1[VB-1:0];
  assign wdata = clr_en_i ? '0 : alu_res;

  always_ff @(posedge clk_i) begin
    if (we) begin
      tree_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= tree_mem[idx_m1[VB-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    sum_q <= sum_d;
    sub_q <= sub_d;
    acc_q <= acc_d;
  end

  assign sts_o.busy = (state_q != W_IDLE);
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;

endmodule

/* sv/fenwick_value_range_count_unit.sv */
// Value range count unit: per-slot value store, sequencer, output register.
// Each Fenwick walk step is a read-then-apply on the tree memory.
// Assign: one update walk, or two (remove old, add new) when the slot already held a value;
// count: a high then a low prefix walk before the output register; empty ranges skip both.
// One item at a time; ready is low until the item is done. After reset a clearing pass
// zeroes tree and occupancy, ready low.
module fenwick_value_range_count_unit import fvrc_pkg::*; #(
  parameter int EMPLOYEES  = 1024,
  parameter int VALUE_BITS = 10
) (
  input logic        clk_i,
  input logic        rst_ni,
  fvrc_in_if.sink    in_i,
  fvrc_out_if.source out_o
);

  localparam int VB     = VALUE_BITS;
  localparam int VSIZE  = 1 << VB;
  localparam int PW     = VB + 1;
  localparam int SLOTS  = (EMPLOYEES > (1 << FIELD_W)) ? (1 << FIELD_W) : EMPLOYEES;
  localparam int SAW    = $clog2(SLOTS);
  localparam int CLEARS = (VSIZE > SLOTS) ? VSIZE : SLOTS;
  localparam int CLW    = $clog2(CLEARS);
  localparam int CWD    = (VB > FIELD_W) ? VB : FIELD_W;
  localparam logic [VB-1:0] VMAX = '1;

  function automatic logic [VB-1:0] clamp_f(input logic [FIELD_W-1:0] v);
    logic [CWD-1:0] w;
    w = CWD'(v);
    return (w > CWD'(VMAX)) ? VMAX : w[VB-1:0];
  endfunction

  logic [VB:0] slot_mem [SLOTS];
  logic [VB:0] slot_rd_q;

  seq_state_e       state_q, state_d;
  logic [CLW-1:0]   clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;
  logic [SAW-1:0]   slot_q;
  logic [VB-1:0]    new_q;
  logic [VB-1:0]    lo_q;
  logic             empty_q;

  logic [VB-1:0]    lo_c, hi_c;
  logic             slot_ok;
  logic             accept;
  logic             slot_re, slot_we;
  logic [SAW-1:0]   slot_waddr;
  logic [VB:0]      slot_wdata;
  logic             tree_clr;

  walk_cmd_t        wcmd;
  logic [PW-1:0]    wpos;
  walk_sts_t        wsts;
  logic [CNT_W-1:0] wacc;

  assign lo_c    = clamp_f(in_i.low_value);
  assign hi_c    = clamp_f(in_i.high_value);
  assign slot_ok = (32'(in_i.employee) < EMPLOYEES);
  assign accept  = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_count_d = out_count_q;
    in_i.ready  = 1'b0;
    slot_re     = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = slot_q;
    slot_wdata  = {1'b1, new_q};
    tree_clr    = 1'b0;
    wcmd        = '0;
    wpos        = '0;
    case (state_q)
      S_CLEAR: begin
        slot_we    = (32'(clr_q) < SLOTS);
        slot_waddr = clr_q[SAW-1:0];
        slot_wdata = '0;
        tree_clr   = (32'(clr_q) < VSIZE);
        clr_d      = clr_q + CLW'(1);
        if (clr_q == CLW'(CLEARS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.action == ACT_COUNT) begin
            if (lo_c > hi_c) begin
              state_d = S_RESULT;
            end else begin
              wcmd.start     = 1'b1;
              wcmd.sum_mode  = 1'b1;
              wcmd.clear_acc = 1'b1;
              wpos           = PW'(hi_c) + PW'(1);
              state_d        = S_HI;
            end
          end else if (slot_ok) begin
            slot_re = 1'b1;
            state_d = S_SLOT;
          end
        end
      end
      S_SLOT: begin
        slot_we    = 1'b1;
        wcmd.start = 1'b1;
        if (slot_rd_q[VB]) begin
          wcmd.sub = 1'b1;
          wpos     = PW'(slot_rd_q[VB-1:0]) + PW'(1);
          state_d  = S_OLD;
        end else begin
          wpos     = PW'(new_q) + PW'(1);
          state_d  = S_NEW;
        end
      end
      S_OLD: begin
        if (wsts.done) begin
          wcmd.start = 1'b1;
          wpos       = PW'(new_q) + PW'(1);
          state_d    = S_NEW;
        end
      end
      S_NEW: begin
        if (wsts.done) begin
          state_d = S_IDLE;
        end
      end
      S_HI: begin
        if (wsts.done) begin
          wcmd.start    = 1'b1;
          wcmd.sum_mode = 1'b1;
          wcmd.sub      = 1'b1;
          wpos          = PW'(lo_q);
          state_d       = S_LO;
        end
      end
      S_LO: begin
        if (wsts.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_count_d = empty_q ? '0 : wacc;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[in_i.employee[SAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
    if (accept) begin
      slot_q  <= in_i.employee[SAW-1:0];
      new_q   <= clamp_f(in_i.salary);
      lo_q    <= lo_c;
      empty_q <= (lo_c > hi_c);
    end
  end

  fvrc_walk #(
    .VALUE_BITS (VALUE_BITS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (wcmd),
    .pos_i      (wpos),
    .clr_en_i   (tree_clr),
    .clr_addr_i (clr_q[VB-1:0]),
    .sts_o      (wsts),
    .acc_o      (wacc)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.count = out_count_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcmd.start |-> !wsts.busy)
    else $error("walk started while busy");

  a_rose_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESULT)
    else $error("result raised outside result state");

  a_assign_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.action == ACT_ASSIGN) |=> !$rose(out_valid_q))
    else $error("assign produced a result");

  a_done_when_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wsts.done |-> (state_q == S_OLD || state_q == S_NEW || state_q == S_HI ||
                   state_q == S_LO))
    else $error("walk finished with no walk pending");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for fenwick_value_range_count_unit: directed then random assign/count
// traffic with random idling on both channels, checked against a per-value histogram.
// Depends on fvrc_pkg and the fvrc_in_if / fvrc_out_if interfaces.
`timescale 1ns / 1ps

module tb_top;
  import fvrc_pkg::*;

  localparam int EMPLOYEES  = 1024;
  localparam int VALUE_BITS = 10;
  localparam int VMAX       = (1 << VALUE_BITS) - 1;
  localparam int IDLE_LIMIT = 6000;
  localparam int RAND_ITEMS = 530;

  typedef struct {
    logic               action;
    logic [FIELD_W-1:0] employee;
    logic [FIELD_W-1:0] salary;
    logic [FIELD_W-1:0] low_value;
    logic [FIELD_W-1:0] high_value;
    int unsigned        gap;
  } staff_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  fvrc_in_if  in_if ();
  fvrc_out_if out_if ();

  fenwick_value_range_count_unit #(
    .EMPLOYEES (EMPLOYEES),
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  staff_item_t        pending_items[$];
  logic [CNT_W-1:0]   counts_due[$];
  logic [FIELD_W-1:0] slot_val[EMPLOYEES];
  bit                 slot_held[EMPLOYEES];
  int                 value_tally[VMAX+1];
  int                 errors;
  int unsigned        hold_cnt;
  int unsigned        stall_left;
  int unsigned        stall_draw;
  int unsigned        idle_cycles;
  bit                 quiet;
  logic [CNT_W-1:0]   want;
  staff_item_t        seen;
  staff_item_t        nxt;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic logic [FIELD_W-1:0] sat_value(input logic [FIELD_W-1:0] v);
    if (v > VMAX) return VMAX;
    return v;
  endfunction

  // Update slot store and histogram; queue the range count for count items.
  task automatic book_item(input staff_item_t it);
    int lo;
    int hi;
    int total;
    if (it.action == ACT_ASSIGN) begin
      if (it.employee < EMPLOYEES) begin
        if (slot_held[it.employee]) value_tally[slot_val[it.employee]]--;
        slot_val[it.employee]  = sat_value(it.salary);
        slot_held[it.employee] = 1'b1;
        value_tally[slot_val[it.employee]]++;
      end
    end else begin
      lo    = sat_value(it.low_value);
      hi    = sat_value(it.high_value);
      total = 0;
      for (int v = lo; v <= hi; v++) total += value_tally[v];
      counts_due.insert(counts_due.size(), total[CNT_W-1:0]);
    end
  endtask

  task automatic queue_item(input staff_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic staff_item_t mk_item(input logic act, input int emp, input int sal,
                                          input int lo, input int hi);
    staff_item_t it;
    it.action     = act;
    it.employee   = emp[FIELD_W-1:0];
    it.salary     = sal[FIELD_W-1:0];
    it.low_value  = lo[FIELD_W-1:0];
    it.high_value = hi[FIELD_W-1:0];
    it.gap        = $urandom_range(0, 7);
    return it;
  endfunction

  function automatic staff_item_t rand_item(input bit calm);
    staff_item_t it;
    int          emp;
    int          sal;
    int          lo;
    int          hi;
    int          tmp;
    int unsigned pick;
    emp  = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
    pick = $urandom_range(0, 3);
    sal  = (pick == 0) ? $urandom_range(0, 15) :
           (pick == 1) ? $urandom_range(1008, 1023) : $urandom_range(0, 1023);
    lo   = $urandom_range(0, 1023);
    hi   = $urandom_range(0, 1023);
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      hi = lo;
    end else if (pick == 1) begin
      lo = 0;
      hi = 1023;
    end else if (pick < 5 && lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    it = mk_item(($urandom_range(0, 9) < 6) ? ACT_ASSIGN : ACT_COUNT, emp, sal, lo, hi);
    if (calm) it.gap = 0;
    return it;
  endfunction

  // Driver: hold the item until accepted, then wait its gap and send the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.action     <= ACT_ASSIGN;
      in_if.employee   <= '0;
      in_if.salary     <= '0;
      in_if.low_value  <= '0;
      in_if.high_value <= '0;
      hold_cnt         <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        seen.action     = in_if.action;
        seen.employee   = in_if.employee;
        seen.salary     = in_if.salary;
        seen.low_value  = in_if.low_value;
        seen.high_value = in_if.high_value;
        book_item(seen);
      end
      if (!in_if.valid || in_if.ready) begin
        if (hold_cnt != 0) begin
          hold_cnt    <= hold_cnt - 1;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_if.valid      <= 1'b1;
          in_if.action     <= nxt.action;
          in_if.employee   <= nxt.employee;
          in_if.salary     <= nxt.salary;
          in_if.low_value  <= nxt.low_value;
          in_if.high_value <= nxt.high_value;
          hold_cnt         <= nxt.gap;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each count, then draw a random stall of ready, which may be none.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      quiet        <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      if (counts_due.size() == 0) begin
        report_mismatch($sformatf("count %0d with no open query", out_if.count));
      end else begin
        want = counts_due.pop_front();
        if (out_if.count !== want)
          report_mismatch($sformatf("count got %0d want %0d", out_if.count, want));
      end
      if ($urandom_range(0, 15) == 0) quiet <= !quiet;
      stall_draw = quiet ? 0 : $urandom_range(0, 7);
      if (stall_draw != 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= stall_draw;
      end
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left   <= 0;
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("fenwick_value_range_count_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit calm;
    errors      = 0;
    calm        = 1'b0;
    foreach (slot_held[i]) slot_held[i] = 1'b0;
    foreach (value_tally[i]) value_tally[i] = 0;

    queue_item(mk_item(ACT_COUNT, 0, 0, 0, 1023));
    queue_item(mk_item(ACT_ASSIGN, 0, 0, 1023, 0));
    queue_item(mk_item(ACT_ASSIGN, 1023, 1023, 0, 0));
    queue_item(mk_item(ACT_ASSIGN, 512, 511, 1023, 1023));
    queue_item(mk_item(ACT_COUNT, 1023, 1023, 0, 1023));
    queue_item(mk_item(ACT_COUNT, 0, 0, 0, 0));
    queue_item(mk_item(ACT_COUNT, 0, 0, 1023, 1023));
    queue_item(mk_item(ACT_COUNT, 0, 0, 1023, 0));
    queue_item(mk_item(ACT_ASSIGN, 0, 1023, 0, 0));
    queue_item(mk_item(ACT_COUNT, 0, 0, 0, 0));
    queue_item(mk_item(ACT_COUNT, 0, 0, 1023, 1023));
    queue_item(mk_item(ACT_ASSIGN, 0, 1023, 0, 0));
    queue_item(mk_item(ACT_COUNT, 0, 0, 511, 1023));
    queue_item(mk_item(ACT_COUNT, 0, 0, 512, 1022));
    queue_item(mk_item(ACT_COUNT, 1023, 1023, 0, 1023));
    queue_item(mk_item(ACT_ASSIGN, 1, 512, 1023, 1023));
    queue_item(mk_item(ACT_ASSIGN, 682, 341, 0, 0));
    queue_item(mk_item(ACT_COUNT, 341, 682, 341, 512));
    queue_item(mk_item(ACT_COUNT, 0, 0, 513, 511));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      queue_item(rand_item(calm));
    end

    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_if.valid || counts_due.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (counts_due.size() != 0)
      report_mismatch($sformatf("%0d counts never returned", counts_due.size()));
    if (errors == 0) begin
      $display("fenwick_value_range_count_unit: match");
    end else begin
      $display("fenwick_value_range_count_unit: mismatch");
    end
    $finish;
  end

endmodule
